FILE: sv/assert_macros.svh
// Assertion helpers shared by the lexer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/stl_pkg.sv
package stl_pkg;

    typedef enum logic [3:0] {
        KIND_UNKNOWN  = 4'd0,
        KIND_LPAREN   = 4'd1,
        KIND_RPAREN   = 4'd2,
        KIND_SEMI     = 4'd3,
        KIND_COLON    = 4'd4,
        KIND_EXIT     = 4'd5,
        KIND_FN       = 4'd6,
        KIND_INT      = 4'd7,
        KIND_LET      = 4'd8,
        KIND_INTLIT   = 4'd9,
        KIND_FLOATLIT = 4'd10,
        KIND_IDENT    = 4'd11
    } kind_t;

    typedef enum logic [1:0] {
        FAULT_NONE         = 2'd0,
        FAULT_EOF_IN_TOKEN = 2'd1,
        FAULT_BLANK_TOKEN  = 2'd2
    } fault_t;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [31:0] KW_EXIT = 32'h6578_6974;
    localparam logic [31:0] KW_FN   = 32'h0000_666E;
    localparam logic [31:0] KW_INT  = 32'h0069_6E74;
    localparam logic [31:0] KW_LET  = 32'h006C_6574;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start;
        logic [7:0]  len;
        fault_t      fault;
    } result_t;

    // One queue entry holds every result caused by one byte.
    typedef struct packed {
        logic    v0;
        result_t r0;
        logic    v1;
        result_t r1;
    } entry_t;

    // Pending-token state, apart from its length counter.
    typedef struct packed {
        logic        pending;
        logic [31:0] start_pos;
        logic [31:0] prefix;
        logic        all_digits;
        logic        dot_seen;
        logic        digits_before_dot;
        logic        digits_after_dot;
        logic        after_dot_all_digits;
        logic        first_is_digit;
        logic        only_blank_ctrl;
    } tok_t;

    localparam tok_t TOK_CLEAR = '{
        pending:              1'b0,
        start_pos:            32'd0,
        prefix:               32'd0,
        all_digits:           1'b1,
        dot_seen:             1'b0,
        digits_before_dot:    1'b0,
        digits_after_dot:     1'b0,
        after_dot_all_digits: 1'b1,
        first_is_digit:       1'b0,
        only_blank_ctrl:      1'b1
    };

    function automatic logic [7:0] sat_len(input logic [15:0] l);
        return (l > 16'd255) ? 8'hFF : l[7:0];
    endfunction

endpackage

FILE: sv/source_token_lexer_unit.sv
// Byte-serial source lexer. One source byte is taken per transfer on the s_
// channel, at up to one byte per clock cycle while the queue has room, and
// classified tokens leave on the m_ channel, one result per transfer with
// m_run_end marking the last result caused by a byte. A byte causes zero,
// one or two results, so the result side gives one result per cycle while
// m_ready is high and a byte that closes a token and is a break character
// gives two results; a four-entry queue between the byte classifier and the
// result sequencer absorbs such bursts and lets either side stall without
// stopping the other. Results pass the queue, then the back end's output
// register. Token lengths count up to MAX_TOKEN_LEN and are reported as at
// most 255; after the byte flagged s_is_final all positions restart at zero.
module source_token_lexer_unit import stl_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_is_final,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [31:0] m_token_start,
    output logic [7:0]  m_token_len,
    output logic [1:0]  m_fault,
    output logic        m_run_end
);

    // Entries written by the classifier and read by the result sequencer.
    logic    q_push, q_ready, q_pop, q_valid;
    entry_t  push_entry, pop_entry;
    result_t res;

    // The front end updates the pending-token flags on every byte transfer and
    // turns each byte that has results into one queue entry holding all of them.
    stl_front #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ch       (s_ch),
        .s_is_final (s_is_final),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    stl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry)
    );

    // The back end holds one entry in its output register and plays its
    // results out in order, the closed token before the break token.
    stl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (pop_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res),
        .m_last  (m_run_end)
    );

    assign m_token_kind  = res.kind;
    assign m_token_start = res.start;
    assign m_token_len   = res.len;
    assign m_fault       = res.fault;

endmodule

FILE: sv/stl_front.sv
`include "assert_macros.svh"

module stl_front import stl_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_is_final,
    input  logic       q_ready,
    output logic       q_push,
    output entry_t     q_entry
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    tok_t             tok_reg, tok_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [31:0]      byte_pos_reg, byte_pos_next;

    logic    accept;
    logic    is_brk, is_space, is_digit, is_blank, first;
    kind_t   brk_kind;
    result_t pend_res;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    assign is_space = (s_ch == CH_SPACE);
    assign is_digit = (s_ch >= CH_ZERO) && (s_ch <= CH_NINE);
    assign is_blank = (s_ch == CH_TAB) || (s_ch == CH_LF) || (s_ch == CH_BS)
                   || (s_ch == CH_FF) || (s_ch == CH_CR);
    assign first    = !tok_reg.pending;

    always_comb begin
        unique case (s_ch)
            CH_LPAREN: begin
                is_brk = 1'b1; brk_kind = KIND_LPAREN;
            end
            CH_RPAREN: begin
                is_brk = 1'b1; brk_kind = KIND_RPAREN;
            end
            CH_SEMI: begin
                is_brk = 1'b1; brk_kind = KIND_SEMI;
            end
            CH_COLON: begin
                is_brk = 1'b1; brk_kind = KIND_COLON;
            end
            default: begin
                is_brk = 1'b0; brk_kind = KIND_UNKNOWN;
            end
        endcase
    end

    // Classify the pending token from the flags kept so far.
    always_comb begin
        pend_res.start = tok_reg.start_pos;
        pend_res.len   = sat_len(16'(len_reg));
        pend_res.fault = FAULT_NONE;
        pend_res.kind  = KIND_UNKNOWN;
        if (tok_reg.only_blank_ctrl) begin
            pend_res.fault = FAULT_BLANK_TOKEN;
        end else if (len_reg == LEN_W'(4) && tok_reg.prefix == KW_EXIT) begin
            pend_res.kind = KIND_EXIT;
        end else if (len_reg == LEN_W'(2) && tok_reg.prefix == KW_FN) begin
            pend_res.kind = KIND_FN;
        end else if (len_reg == LEN_W'(3) && tok_reg.prefix == KW_INT) begin
            pend_res.kind = KIND_INT;
        end else if (len_reg == LEN_W'(3) && tok_reg.prefix == KW_LET) begin
            pend_res.kind = KIND_LET;
        end else if (tok_reg.all_digits) begin
            pend_res.kind = KIND_INTLIT;
        end else if (tok_reg.dot_seen && tok_reg.digits_before_dot
                     && tok_reg.digits_after_dot && tok_reg.after_dot_all_digits) begin
            pend_res.kind = KIND_FLOATLIT;
        end else if (!tok_reg.first_is_digit) begin
            pend_res.kind = KIND_IDENT;
        end
    end

    always_comb begin
        tok_next      = tok_reg;
        len_next      = len_reg;
        byte_pos_next = byte_pos_reg;
        q_entry       = '0;
        if (accept) begin
            byte_pos_next = byte_pos_reg + 32'd1;
            if (is_brk || is_space) begin
                if (tok_reg.pending) begin
                    q_entry.v0 = 1'b1;
                    q_entry.r0 = pend_res;
                    tok_next   = TOK_CLEAR;
                    len_next   = '0;
                end
                if (is_brk) begin
                    q_entry.v1 = 1'b1;
                    q_entry.r1 = '{kind: brk_kind, start: byte_pos_reg,
                                   len: 8'd1, fault: FAULT_NONE};
                end
            end else begin
                if (first) begin
                    tok_next.pending        = 1'b1;
                    tok_next.start_pos      = byte_pos_reg;
                    tok_next.first_is_digit = is_digit;
                end
                if (len_reg < LEN_W'(4)) begin
                    tok_next.prefix = {tok_reg.prefix[23:0], s_ch};
                end
                tok_next.only_blank_ctrl = tok_reg.only_blank_ctrl && is_blank;
                if (tok_reg.dot_seen) begin
                    tok_next.digits_after_dot     = 1'b1;
                    tok_next.after_dot_all_digits = tok_reg.after_dot_all_digits
                                                 && is_digit;
                end else if (s_ch == CH_DOT) begin
                    tok_next.dot_seen          = 1'b1;
                    tok_next.digits_before_dot = tok_reg.all_digits && !first;
                end
                tok_next.all_digits = tok_reg.all_digits && is_digit;
                if (len_reg < LEN_W'(MAX_TOKEN_LEN)) begin
                    len_next = len_reg + LEN_W'(1);
                end
                if (s_is_final) begin
                    q_entry.v0 = 1'b1;
                    q_entry.r0 = '{kind: KIND_UNKNOWN, start: tok_next.start_pos,
                                   len: sat_len(16'(len_next)),
                                   fault: FAULT_EOF_IN_TOKEN};
                end
            end
            if (s_is_final) begin
                tok_next      = TOK_CLEAR;
                len_next      = '0;
                byte_pos_next = '0;
            end
        end
    end

    assign q_push = accept && (q_entry.v0 || q_entry.v1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg      <= TOK_CLEAR;
            len_reg      <= '0;
            byte_pos_reg <= '0;
        end else begin
            tok_reg      <= tok_next;
            len_reg      <= len_next;
            byte_pos_reg <= byte_pos_next;
        end
    end

    `ASSERT_IMPLIES(a_pending_has_len, aclk, aresetn, tok_reg.pending, len_reg != '0)
    `ASSERT_NEXT(a_final_clears, aclk, aresetn, accept && s_is_final,
                 byte_pos_reg == '0 && !tok_reg.pending)

endmodule

FILE: sv/stl_queue.sv
`include "assert_macros.svh"

module stl_queue import stl_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   push_ready,
    input  logic   pop,
    output logic   pop_valid,
    output entry_t pop_entry
);

    entry_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, push, push_ready)
    `ASSERT_IMPLIES(a_no_underflow, aclk, aresetn, pop, pop_valid)

endmodule

FILE: sv/stl_back.sv
`include "assert_macros.svh"

module stl_back import stl_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  entry_t  q_entry,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res,
    output logic    m_last
);

    entry_t cur_reg, cur_next;
    logic   has_reg, has_next;
    logic   sel_reg, sel_next;
    logic   done, load;

    assign m_valid = has_reg;
    assign m_res   = sel_reg ? cur_reg.r1 : cur_reg.r0;
    assign m_last  = sel_reg || !cur_reg.v1;
    assign done    = m_valid && m_ready && m_last;
    assign load    = !has_reg || done;
    assign q_pop   = q_valid && load;

    always_comb begin
        cur_next = cur_reg;
        has_next = has_reg;
        sel_next = sel_reg;
        if (load) begin
            has_next = q_valid;
            if (q_valid) begin
                cur_next = q_entry;
                sel_next = !q_entry.v0;
            end
        end else if (m_valid && m_ready) begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_reg <= 1'b0;
            sel_reg <= 1'b0;
        end else begin
            has_reg <= has_next;
            sel_reg <= sel_next;
        end
    end

    `ASSERT_IMPLIES(a_slot_valid, aclk, aresetn, has_reg,
                    (sel_reg && cur_reg.v1) || (!sel_reg && cur_reg.v0))

endmodule
